// ===== rtl/assert_macros.svh =====
// assertion macros used by the port level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ===== rtl/hofdp_pkg.sv =====
// shared types and constants for the depot cost engine
// no dependencies
`default_nettype none
package hofdp_pkg;
   localparam int unsigned DEPTH = 1024;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   typedef struct packed {
      logic [31:0] position;
      logic [15:0] goods_count;
      logic [31:0] build_cost;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] cost_here;
      logic signed [63:0] answer;
      logic               is_last;
      logic               overflow;
   } rsp_type;

   // slope classes, ordered as on the extended real line
   typedef enum logic [1:0] {
      SL_NONE = 2'd0,
      SL_NINF = 2'd1,
      SL_FIN  = 2'd2,
      SL_PINF = 2'd3
   } slope_cls_type;
endpackage
`default_nettype wire

// ===== rtl/hofdp_if.sv =====
// valid/ready channel carrying one packed payload
// depends on hofdp_pkg
`default_nettype none
interface hofdp_req_if (input wire logic clock);
   import hofdp_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface hofdp_rsp_if (input wire logic clock);
   import hofdp_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hull_optimized_facility_dp.sv =====
// Depot cost engine: convex hull trick over a monotone deque.
// Channels: req (sink) takes one site per request; rsp (source) gives one
// result per request, in order. A request is taken when valid and ready are
// high at a rising clock edge.
// The hull points live in two synchronous memories (x and y), each read
// through a registered output. Per site: prefix update, then front pops (two
// memory reads and a compare per pop), the cost from the front point, then
// back pops (reads of back and its predecessor, two 32x32 product halves
// per slope product), then the push write.
// req ready returns in the cycle after the result is loaded, so sites are
// worked one at a time.
// Reset (synchronous, active high) clears the pointers and prefix sums;
// entry 0 reads as (0,0) through a flag until its memory entry is written,
// so no clearing pass is needed.
// If rsp is stalled the result holds in the output register and at most
// one further site is worked up to its result before req waits.
// After a site marked last, pointers, prefix sums, minimum and entry-0 flag reset.
`default_nettype none
module hull_optimized_facility_dp (
   input wire logic clock,
   input wire logic reset,
   hofdp_req_if.sink   req,
   hofdp_rsp_if.source rsp
);
   import hofdp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_FR_RD, S_FR_WT, S_FR_CMP, S_COST_RD, S_COST_WT, S_COST,
      S_BK_CHK, S_BK_RD, S_BK_WT, S_BK_M0, S_BK_M1, S_BK_M2, S_BK_M3,
      S_BK_CMP, S_PUSH, S_OUT
   } state_type;

   // memories
   logic [31:0] mem_x [DEPTH];
   logic [63:0] mem_y [DEPTH];
   logic [PTR_W-1:0] rd_addr_a, rd_addr_b;
   logic [31:0] rdx_a_ff, rdx_b_ff;
   logic [63:0] rdy_a_ff, rdy_b_ff;
   logic wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [31:0] wr_x;
   logic [63:0] wr_y;
   // entry 0 reads as zero until written after a reset
   logic zero_valid_ff;

   state_type state_ff;
   req_type   cur_ff;
   logic [31:0] pc_ff;
   logic [63:0] pw_ff;
   logic [PTR_W-1:0] front_ff, back_ff;
   logic [63:0] tmin_ff;
   logic [63:0] f_ff, yi_ff;
   logic [31:0] ax_ff, bx_ff;
   logic [63:0] ay_ff, by_ff;
   logic [63:0] fy_ff;
   // slope products
   logic [63:0] p_lo_ff, p_hi_ff;
   logic [95:0] prod_a_ff, prod_b_ff;
   logic        ovf_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      rdx_a_ff <= mem_x[rd_addr_a];
      rdy_a_ff <= mem_y[rd_addr_a];
      rdx_b_ff <= mem_x[rd_addr_b];
      rdy_b_ff <= mem_y[rd_addr_b];
   end

   logic [PTR_W-1:0] ra_q_ff, rb_q_ff;
   logic [31:0] rxa, rxb;
   logic [63:0] rya, ryb;
   always_comb begin
      rxa = (ra_q_ff == '0 && !zero_valid_ff) ? 32'd0 : rdx_a_ff;
      rya = (ra_q_ff == '0 && !zero_valid_ff) ? 64'd0 : rdy_a_ff;
      rxb = (rb_q_ff == '0 && !zero_valid_ff) ? 32'd0 : rdx_b_ff;
      ryb = (rb_q_ff == '0 && !zero_valid_ff) ? 64'd0 : rdy_b_ff;
   end

   function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
      return (32'(p) + 32'd1 >= DEPTH) ? '0 : p + 1'b1;
   endfunction
   function automatic logic [PTR_W-1:0] prv(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   // front slope test: slope(a->b) <= position
   logic [63:0] fdy, fmag;
   logic [31:0] fdx;
   logic        fneg, f_le;
   logic [63:0] fprod_ff;
   always_comb begin
      fdy  = ryb - rya;
      fneg = fdy[63];
      fmag = fneg ? -fdy : fdy;
      fdx  = rxb - rxa;
      if (fdx == 32'd0) f_le = (fmag != 64'd0) && fneg;
      else f_le = fneg || (fmag <= fprod_ff);
   end

   // back slope parts: s1 = a->b (prev->back), s2 = b->new
   logic [63:0] dy1, dy2, m1, m2;
   logic [31:0] dx1, dx2;
   logic        n1, n2;
   slope_cls_type c1, c2;
   always_comb begin
      dy1 = by_ff - ay_ff;
      dx1 = bx_ff - ax_ff;
      dy2 = yi_ff - by_ff;
      dx2 = pc_ff - bx_ff;
      n1  = dy1[63];
      n2  = dy2[63];
      m1  = n1 ? -dy1 : dy1;
      m2  = n2 ? -dy2 : dy2;
      c1  = (dx1 != 0) ? SL_FIN : (m1 == 0) ? SL_NONE : n1 ? SL_NINF : SL_PINF;
      c2  = (dx2 != 0) ? SL_FIN : (m2 == 0) ? SL_NONE : n2 ? SL_NINF : SL_PINF;
   end

   // shared 32x32 multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         S_BK_M0: begin mul_a = m1[31:0];  mul_b = dx2; end
         S_BK_M1: begin mul_a = m1[63:32]; mul_b = dx2; end
         S_BK_M2: begin mul_a = m2[31:0];  mul_b = dx1; end
         S_BK_M3: begin mul_a = m2[63:32]; mul_b = dx1; end
         default: begin mul_a = 32'd0;     mul_b = 32'd0; end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   logic s_gt;
   logic an, bn, mgt, mlt;
   always_comb begin
      an  = n1 && (prod_a_ff != 0);
      bn  = n2 && (prod_b_ff != 0);
      mgt = prod_a_ff > prod_b_ff;
      mlt = prod_a_ff < prod_b_ff;
      if (c1 == SL_NONE || c2 == SL_NONE) s_gt = 1'b0;
      else if (c1 != SL_FIN || c2 != SL_FIN) s_gt = c1 > c2;
      else if (an != bn) s_gt = bn;
      else s_gt = an ? mlt : mgt;
   end

   logic [PTR_W-1:0] cnt_m1;
   logic [31:0] x_cur;
   assign x_cur  = cur_ff.position;
   assign cnt_m1 = back_ff - front_ff;

   // read address and write port selection
   always_comb begin
      rd_addr_a = front_ff;
      rd_addr_b = nxt(front_ff);
      case (state_ff)
         S_BK_RD: begin rd_addr_a = prv(back_ff); rd_addr_b = back_ff; end
         default: begin rd_addr_a = front_ff; rd_addr_b = nxt(front_ff); end
      endcase
      wr_en   = (state_ff == S_PUSH) && (cnt_m1 != PTR_W'(DEPTH - 1));
      wr_addr = nxt(back_ff);
      wr_x    = pc_ff;
      wr_y    = yi_ff;
   end

   logic req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // output register free for a finished site
   logic out_load;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   logic [63:0] tmin_new;
   logic        last_ovf;
   always_comb begin
      if (cur_ff.goods_count != 0) tmin_new = f_ff;
      else if ($signed(f_ff) < $signed(tmin_ff)) tmin_new = f_ff;
      else tmin_new = tmin_ff;
      last_ovf = (cnt_m1 == PTR_W'(DEPTH - 1));
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= '0;
         pw_ff         <= '0;
         front_ff      <= '0;
         back_ff       <= '0;
         tmin_ff       <= '0;
         zero_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         ra_q_ff <= rd_addr_a;
         rb_q_ff <= rd_addr_b;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  cur_ff <= req.data;
                  pc_ff  <= pc_ff + 32'(req.data.goods_count);
                  pw_ff  <= pw_ff + 64'(req.data.position) * 64'(req.data.goods_count);
                  state_ff <= S_FR_RD;
               end
            end
            S_FR_RD: begin
               state_ff <= (front_ff == back_ff) ? S_COST_RD : S_FR_WT;
            end
            S_FR_WT: begin
               fprod_ff <= 64'(x_cur) * 64'(fdx);
               state_ff <= S_FR_CMP;
            end
            S_FR_CMP: begin
               if (f_le) begin
                  front_ff <= nxt(front_ff);
                  state_ff <= S_FR_RD;
               end else begin
                  state_ff <= S_COST_RD;
               end
            end
            S_COST_RD: state_ff <= S_COST_WT;
            S_COST_WT: begin
               fy_ff    <= rya;
               p_lo_ff  <= 64'(pc_ff - rxa) * 64'(x_cur);
               state_ff <= S_COST;
            end
            S_COST: begin
               f_ff     <= fy_ff - pw_ff + p_lo_ff + 64'(cur_ff.build_cost);
               yi_ff    <= fy_ff + p_lo_ff + 64'(cur_ff.build_cost);
               state_ff <= S_BK_CHK;
            end
            S_BK_CHK: state_ff <= (front_ff == back_ff) ? S_PUSH : S_BK_RD;
            S_BK_RD: state_ff <= S_BK_WT;
            S_BK_WT: begin
               ax_ff <= rxa; ay_ff <= rya;
               bx_ff <= rxb; by_ff <= ryb;
               state_ff <= S_BK_M0;
            end
            S_BK_M0: begin p_lo_ff <= mul_p; state_ff <= S_BK_M1; end
            S_BK_M1: begin
               prod_a_ff <= {mul_p, 32'd0} + 96'(p_lo_ff);
               state_ff  <= S_BK_M2;
            end
            S_BK_M2: begin p_hi_ff <= mul_p; state_ff <= S_BK_M3; end
            S_BK_M3: begin
               prod_b_ff <= {mul_p, 32'd0} + 96'(p_hi_ff);
               state_ff  <= S_BK_CMP;
            end
            S_BK_CMP: begin
               if (s_gt) begin
                  back_ff  <= prv(back_ff);
                  state_ff <= S_BK_CHK;
               end else begin
                  state_ff <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (!last_ovf) begin
                  back_ff <= nxt(back_ff);
                  if (nxt(back_ff) == '0) zero_valid_ff <= 1'b1;
               end
               ovf_ff   <= last_ovf;
               tmin_ff  <= tmin_new;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_ff.cost_here  <= f_ff;
                  rsp_ff.answer     <= cur_ff.last ? tmin_ff : 64'd0;
                  rsp_ff.is_last    <= cur_ff.last;
                  rsp_ff.overflow   <= ovf_ff;
                  state_ff          <= S_IDLE;
                  if (cur_ff.last) begin
                     pc_ff <= '0; pw_ff <= '0; front_ff <= '0; back_ff <= '0;
                     tmin_ff <= '0; zero_valid_ff <= 1'b0;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/hofdp_checker.sv =====
// port level checks for the depot cost engine
// depends on assert_macros.svh and the channel interfaces
`default_nettype none
`include "assert_macros.svh"
module hofdp_props (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_is_last,
   input wire logic signed [63:0] rsp_answer
);
   // a waiting result holds until taken
   `CHK_IMPLY(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid, "rsp dropped")
   // answer is zero unless the run closes
   `CHK_IMPLY(a_ans_zero, clock, reset, rsp_valid && !rsp_is_last, rsp_answer == 64'd0, "answer")
   // a request is not taken on the edge after one was taken
   `CHK_IMPLY(a_one_at_time, clock, reset, req_valid && req_ready, ##1 !req_ready, "ready")
endmodule

bind hull_optimized_facility_dp hofdp_props u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_is_last(rsp.data.is_last), .rsp_answer(rsp.data.answer)
);
`default_nettype wire

// ===== dv/hofdp_checker.sv =====
// checker for the depot cost engine: predicts each result from the requests
// depends on hofdp_pkg and the channel interfaces in hofdp_if
`timescale 1ns / 100ps
`default_nettype none
module hofdp_checker (
   input wire logic clock,
   input wire logic reset,
   hofdp_req_if     req,
   hofdp_rsp_if     rsp,
   output int       fail_count,
   output int       pending_count,
   output int       result_count,
   output int       overflow_count,
   output int       run_count
);
   import hofdp_pkg::*;

   // hull state of the predictor
   logic [31:0] sum_goods;
   logic [63:0] sum_weighted;
   logic [31:0] pt_x [DEPTH];
   logic [63:0] pt_y [DEPTH];
   int unsigned head;
   int unsigned tail;
   logic [63:0] run_min;
   rsp_type     expected_rsp [$];

   typedef struct {
      slope_cls_type cls;
      logic          neg;
      logic [63:0]   mag;
      logic [31:0]   dx;
   } slope_type;

   function automatic slope_type slope_of(logic [31:0] xa, logic [63:0] ya,
                                          logic [31:0] xb, logic [63:0] yb);
      slope_type s;
      logic [63:0] dy;
      dy    = yb - ya;
      s.neg = dy[63];
      s.mag = s.neg ? -dy : dy;
      s.dx  = xb - xa;
      if (s.dx != 0) s.cls = SL_FIN;
      else if (s.mag == 0) s.cls = SL_NONE;
      else s.cls = s.neg ? SL_NINF : SL_PINF;
      return s;
   endfunction

   // exact cross-multiplied compare, unordered compares false
   function automatic logic steeper(slope_type a, slope_type b);
      logic [95:0] pa;
      logic [95:0] pb;
      logic        an;
      logic        bn;
      if (a.cls == SL_NONE || b.cls == SL_NONE) return 1'b0;
      if (a.cls != SL_FIN || b.cls != SL_FIN) return a.cls > b.cls;
      pa = a.mag * {64'd0, b.dx};
      pb = b.mag * {64'd0, a.dx};
      an = a.neg && pa != 0;
      bn = b.neg && pb != 0;
      if (an != bn) return bn;
      return an ? (pa < pb) : (pa > pb);
   endfunction

   function automatic logic not_above(slope_type s, logic [31:0] x);
      logic [95:0] lim;
      if (s.cls == SL_NONE || s.cls == SL_PINF) return 1'b0;
      if (s.cls == SL_NINF || s.neg) return 1'b1;
      lim = {64'd0, x} * {64'd0, s.dx};
      return {32'd0, s.mag} <= lim;
   endfunction

   task automatic clear_hull();
      sum_goods    = 0;
      sum_weighted = 0;
      head         = 0;
      tail         = 0;
      run_min      = 0;
      pt_x[0]      = 0;
      pt_y[0]      = 0;
   endtask

   // one site through the hull, result queued
   task automatic predict_site(req_type r);
      int unsigned nx;
      int unsigned pv;
      int unsigned held;
      logic [63:0] f;
      logic [63:0] yi;
      logic [31:0] dcount;
      rsp_type     e;
      sum_goods    = sum_goods + {16'd0, r.goods_count};
      sum_weighted = sum_weighted + {32'd0, r.position} * {48'd0, r.goods_count};
      while (head != tail) begin
         nx = (head + 1) % DEPTH;
         if (!not_above(slope_of(pt_x[head], pt_y[head], pt_x[nx], pt_y[nx]), r.position))
            break;
         head = nx;
      end
      dcount = sum_goods - pt_x[head];
      f  = pt_y[head] - sum_weighted + {32'd0, dcount} * {32'd0, r.position}
           + {32'd0, r.build_cost};
      yi = f + sum_weighted;
      while (head != tail) begin
         pv = (tail + DEPTH - 1) % DEPTH;
         if (!steeper(slope_of(pt_x[pv], pt_y[pv], pt_x[tail], pt_y[tail]),
                      slope_of(pt_x[tail], pt_y[tail], sum_goods, yi)))
            break;
         tail = pv;
      end
      held = (tail + DEPTH - head) % DEPTH + 1;
      e.overflow = held >= DEPTH;
      if (!e.overflow) begin
         tail       = (tail + 1) % DEPTH;
         pt_x[tail] = sum_goods;
         pt_y[tail] = yi;
      end
      if (r.goods_count != 0 || $signed(f) < $signed(run_min)) run_min = f;
      e.cost_here = f;
      e.answer    = r.last ? run_min : 64'd0;
      e.is_last   = r.last;
      expected_rsp.push_back(e);
      if (r.last) clear_hull();
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         clear_hull();
         expected_rsp.delete();
         fail_count     <= 0;
         result_count   <= 0;
         overflow_count <= 0;
         run_count      <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            a = rsp.data;
            result_count <= result_count + 1;
            if (a.overflow) overflow_count <= overflow_count + 1;
            if (a.is_last) run_count <= run_count + 1;
            if (expected_rsp.size() == 0) begin
               $error("result with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsp.pop_front();
               if (a !== e) begin
                  fail_count <= fail_count + 1;
                  if (a.cost_here !== e.cost_here)
                     $error("cost_here expected %0d got %0d", e.cost_here, a.cost_here);
                  if (a.answer !== e.answer)
                     $error("answer expected %0d got %0d", e.answer, a.answer);
                  if (a.is_last !== e.is_last)
                     $error("is_last expected %0d got %0d", e.is_last, a.is_last);
                  if (a.overflow !== e.overflow)
                     $error("overflow expected %0d got %0d", e.overflow, a.overflow);
               end
            end
         end
         if (req.valid && req.ready) predict_site(req.data);
      end
      pending_count = expected_rsp.size();
   end

endmodule
`default_nettype wire

// ===== dv/hull_optimized_facility_dp_tb.sv =====
// top of the depot cost engine testbench: clock, reset, requests, verdict
// depends on hofdp_pkg, hofdp_if, hofdp_checker and the block itself
`timescale 1ns / 100ps
`default_nettype none
module hull_optimized_facility_dp_tb;
   import hofdp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   result_count;
   int   overflow_count;
   int   run_count;
   int   cycle_count = 0;
   int   request_count = 0;
   logic [31:0] cur_pos;

   hofdp_req_if req (clock);
   hofdp_rsp_if rsp (clock);

   hull_optimized_facility_dp dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   hofdp_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .result_count   (result_count),
      .overflow_count (overflow_count),
      .run_count      (run_count)
   );

   always #1 clock = ~clock;

   // receiver stall pattern, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (cycle_count % 2000 < 300) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hull_optimized_facility_dp: mismatch");
         $finish;
      end
   end

   // present one request and hold it until ready is sampled high after an edge
   task automatic send_site(logic [31:0] pos, logic [15:0] goods, logic [31:0] cost,
                            logic fin);
      req_type r;
      r.position    = pos;
      r.goods_count = goods;
      r.build_cost  = cost;
      r.last        = fin;
      req.valid <= 1'b1;
      req.data  <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      request_count++;
   endtask

   task automatic idle_cycles(int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off requests until every expected result has come
   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random site: small or extreme values, position only stepped forward, with 32-bit wrap
   task automatic random_site(logic fin);
      logic [15:0] goods;
      logic [31:0] cost;
      case ($urandom_range(0, 9))
         0: cur_pos = cur_pos + $urandom;
         1, 2: ;
         default: cur_pos = cur_pos + $urandom_range(0, 20);
      endcase
      case ($urandom_range(0, 5))
         0: goods = 16'd0;
         1: goods = 16'($urandom);
         2: goods = 16'hffff;
         default: goods = 16'($urandom_range(0, 9));
      endcase
      cost = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200);
      send_site(cur_pos, goods, cost, fin);
   endtask

   initial begin
      int len;
      bit long_done;
      long_done = 1'b0;
      req.valid = 1'b0;
      req.data  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero-count tails, equal positions and counts
      send_site(32'd0, 16'd0, 32'd0, 1'b1);
      send_site(32'd0, 16'd0, 32'd5, 1'b0);
      send_site(32'd0, 16'd0, 32'd3, 1'b1);
      send_site(32'd0, 16'hffff, 32'hffffffff, 1'b0);
      send_site(32'd10, 16'hffff, 32'd0, 1'b0);
      send_site(32'hffffffff, 16'hffff, 32'hffffffff, 1'b0);
      send_site(32'hffffffff, 16'd0, 32'd1, 1'b0);
      send_site(32'hffffffff, 16'd0, 32'd0, 1'b1);
      send_site(32'd5, 16'd3, 32'd7, 1'b0);
      send_site(32'd5, 16'd3, 32'd7, 1'b0);
      send_site(32'd5, 16'd0, 32'd100, 1'b0);
      send_site(32'd6, 16'd0, 32'd0, 1'b0);
      send_site(32'd9, 16'd2, 32'd50, 1'b0);
      send_site(32'd9, 16'd0, 32'd2, 1'b1);
      send_site(32'h80000000, 16'h8000, 32'h80000000, 1'b0);
      send_site(32'hc0000000, 16'h7fff, 32'h7fffffff, 1'b0);
      send_site(32'hfffffffe, 16'd1, 32'd0, 1'b1);
      drain();

      // random runs in bursts, one long run
      while (request_count < 720) begin
         cur_pos = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100);
         if (!long_done && request_count >= 200) begin
            len = 300;
            long_done = 1'b1;
         end else begin
            len = int'($urandom_range(1, 40));
         end
         for (int k = 0; k < len; k++) begin
            random_site(k == len - 1);
            if ($urandom_range(0, 7) == 0) idle_cycles(int'($urandom_range(1, 12)));
         end
         if ($urandom_range(0, 5) == 0) drain();
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d requests in %0d runs, %0d results with deque overflow",
               request_count, run_count, overflow_count);
      if (fail_count == 0) begin
         $display("hull_optimized_facility_dp: match");
      end else begin
         $display("hull_optimized_facility_dp: mismatch");
      end
      $finish;
   end

endmodule
`default_nettype wire
